### rtl/core/msos_pkg.sv
// Shared types and constants of the multisite occupancy scale block.
// Used by every module in rtl/core; depends on nothing.
package msos_pkg;

   // Array geometry
   localparam int NUM_STATES   = 8;
   localparam int NUM_SITES    = 8;
   localparam int NUM_PAIRS    = NUM_STATES / 2;
   localparam int FRAC_W       = 16;
   localparam int RATE_W       = 16;
   localparam int COUNT_W      = 4;
   localparam int CSR_DATA_W   = 64;
   localparam int CSR_INDEX_W  = 3;
   localparam int SF_W         = 28;

   // Pipeline layout: input register, one stage per site, three merge stages
   localparam int MERGE_STAGES = 3;
   localparam int PIPE_STAGES  = 1 + NUM_SITES + MERGE_STAGES;

   // Merge arithmetic widths
   localparam int PROD_W = 2 * FRAC_W;
   localparam int TERM_W = PROD_W + 1;
   localparam int PAIR_W = TERM_W + 1;
   localparam int ACC_W  = TERM_W + 4;

   // Fixed-point constants
   localparam logic [FRAC_W-1:0] ONE_Q15   = 16'd32768;
   localparam logic [PROD_W-1:0] ROUND_Q15 = 32'd16384;
   // 1.0 in Q.23 plus the half-step for rounding to Q16
   localparam logic signed [ACC_W-1:0] ACC_BIAS = 37'sd8388672;
   localparam logic signed [ACC_W-1:0] SF_HI    = 37'sd134217727;
   localparam logic signed [ACC_W-1:0] SF_LO    = -37'sd134217728;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_N_STATES      = 3'd0,
      CSR_N_SITES       = 3'd1,
      CSR_CARE_MASK     = 3'd2,
      CSR_OCCUPIED_MASK = 3'd3,
      CSR_RATES_LOW     = 3'd4,
      CSR_RATES_HIGH    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [COUNT_W-1:0]    n_states;
      logic [COUNT_W-1:0]    n_sites;
      logic [CSR_DATA_W-1:0] care_mask;
      logic [CSR_DATA_W-1:0] occupied_mask;
      logic [CSR_DATA_W-1:0] rates_low;
      logic [CSR_DATA_W-1:0] rates_high;
   } cfg_type;

   typedef logic [NUM_STATES-1:0][FRAC_W-1:0] occ_vec_type;
   typedef logic [NUM_SITES-1:0][FRAC_W-1:0]  frac_vec_type;

   // Merge stage load enables
   typedef struct packed {
      logic term_load;
      logic pair_load;
      logic out_load;
   } merge_ctl_type;

endpackage

### rtl/core/msos_csr.sv
// Configuration registers of the multisite occupancy scale block.
// Depends on msos_pkg for the register indexes and cfg_type.
module msos_csr import msos_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff, cfg_in;

   // Register write decode; unknown indexes leave everything as is
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_N_STATES:      cfg_in.n_states      = csr_write_data[COUNT_W-1:0];
            CSR_N_SITES:       cfg_in.n_sites       = csr_write_data[COUNT_W-1:0];
            CSR_CARE_MASK:     cfg_in.care_mask     = csr_write_data;
            CSR_OCCUPIED_MASK: cfg_in.occupied_mask = csr_write_data;
            CSR_RATES_LOW:     cfg_in.rates_low     = csr_write_data;
            CSR_RATES_HIGH:    cfg_in.rates_high    = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.n_states      <= COUNT_W'(1);
         cfg_ff.n_sites       <= COUNT_W'(1);
         cfg_ff.care_mask     <= '0;
         cfg_ff.occupied_mask <= '0;
         cfg_ff.rates_low     <= '0;
         cfg_ff.rates_high    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/msos_lane.sv
// One state lane: a chain of Q1.15 multiply stages, one per binding site.
// Depends on msos_pkg for widths and constants.
module msos_lane import msos_pkg::*; (
   input  logic                 clock,
   input  logic [NUM_SITES-1:0] stage_load,
   input  frac_vec_type         frac_in,
   input  logic [NUM_SITES-1:0] care_bits,
   input  logic [NUM_SITES-1:0] occupied_bits,
   input  logic [COUNT_W-1:0]   n_sites,
   output logic [FRAC_W-1:0]    occ_out
);

   logic [NUM_SITES-1:0][FRAC_W-1:0] occ_ff;

   for (genvar j = 0; j < NUM_SITES; j++) begin : g_site
      logic [FRAC_W-1:0] occ_src;
      logic [FRAC_W-1:0] factor;
      logic [PROD_W-1:0] prod;
      logic              site_used;

      // Site j multiplies by f, by 1 - f, or by exactly 1 when it does not matter
      always_comb begin
         site_used = care_bits[j] && (COUNT_W'(j) < n_sites);
         if (!site_used) begin
            factor = ONE_Q15;
         end else if (occupied_bits[j]) begin
            factor = frac_in[j];
         end else begin
            factor = ONE_Q15 - frac_in[j];
         end
      end

      if (j == 0) begin : g_first
         assign occ_src = ONE_Q15;
      end else begin : g_next
         assign occ_src = occ_ff[j-1];
      end

      // Rounded Q1.15 product; never exceeds 1.0
      assign prod = PROD_W'(occ_src) * PROD_W'(factor) + ROUND_Q15;

      always_ff @(posedge clock) begin
         if (stage_load[j]) begin
            occ_ff[j] <= prod[FRAC_W+14:15];
         end
      end
   end

   assign occ_out = occ_ff[NUM_SITES-1];

endmodule

### rtl/core/msos_merge.sv
// Merge stage: weights each lane's occupancy by its rate, sums over lanes,
// rounds to Q12.16 and saturates. Depends on msos_pkg.
module msos_merge import msos_pkg::*; (
   input  logic                  clock,
   input  merge_ctl_type         ctl,
   input  occ_vec_type           occ_in,
   input  logic [NUM_STATES-1:0][RATE_W-1:0] rates,
   input  logic [COUNT_W-1:0]    n_states,
   output occ_vec_type           occ_out,
   output logic signed [SF_W-1:0] sf_out
);

   occ_vec_type                                 occ_t_ff, occ_p_ff, occ_o_ff;
   logic signed [NUM_STATES-1:0][TERM_W-1:0]    term_in, term_ff;
   logic signed [NUM_PAIRS-1:0][PAIR_W-1:0]     pair_in, pair_ff;
   occ_vec_type                                 occ_t_in;
   logic signed [ACC_W-1:0]                     acc, rounded;
   logic signed [SF_W-1:0]                      sf_in, sf_ff;

   // Per state: occ * rate - occ * 256, inactive states forced to zero
   always_comb begin
      for (int s = 0; s < NUM_STATES; s++) begin
         logic [PROD_W-1:0] prod;
         occ_t_in[s] = (COUNT_W'(s) < n_states) ? occ_in[s] : '0;
         prod        = PROD_W'(occ_t_in[s]) * PROD_W'(rates[s]);
         term_in[s]  = $signed({1'b0, prod})
                     - $signed({{(TERM_W-FRAC_W-8){1'b0}}, occ_t_in[s], 8'b0});
      end
   end

   // Pairwise sums; elements of a packed array read back unsigned
   always_comb begin
      for (int p = 0; p < NUM_PAIRS; p++) begin
         pair_in[p] = PAIR_W'($signed(term_ff[2*p])) + PAIR_W'($signed(term_ff[2*p+1]));
      end
   end

   // Final sum with 1.0 and rounding bias, floor shift, saturate
   always_comb begin
      acc = ACC_BIAS;
      for (int p = 0; p < NUM_PAIRS; p++) begin
         acc = acc + ACC_W'($signed(pair_ff[p]));
      end
      rounded = acc >>> 7;
      priority if (rounded > SF_HI) begin
         sf_in = SF_HI[SF_W-1:0];
      end else if (rounded < SF_LO) begin
         sf_in = SF_LO[SF_W-1:0];
      end else begin
         sf_in = rounded[SF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.term_load) begin
         occ_t_ff <= occ_t_in;
         term_ff  <= term_in;
      end
      if (ctl.pair_load) begin
         occ_p_ff <= occ_t_ff;
         pair_ff  <= pair_in;
      end
      if (ctl.out_load) begin
         occ_o_ff <= occ_p_ff;
         sf_ff    <= sf_in;
      end
   end

   assign occ_out = occ_o_ff;
   assign sf_out  = sf_ff;

endmodule

### rtl/core/multisite_occupancy_scale.sv
// Top level of the multisite occupancy scale block: flow control, fraction
// delay line, eight state lanes and the merge stage. Depends on msos_pkg,
// msos_csr, msos_lane and msos_merge.
//
// Usage:
//  - Request channel (req_valid/req_ready) carries eight Q1.15 site fractions;
//    values above 1.0 are taken as 1.0.
//  - Response channel (rsp_valid/rsp_ready) returns the eight state
//    occupancies and the signed Q12.16 scale factor, one response per request.
//  - Configuration is written through csr_write_enable/csr_index/
//    csr_write_data, by the user only while no request is in flight (the
//    block does not enforce this); writes to unknown indexes are dropped.
//  - Pipeline: an accepted request passes the input register, one multiply
//    stage per site and three merge stages (rate multiply, pair add, final
//    add with rounding) before its response is presented.
//  - Throughput: one request per cycle while the pipeline is not full; the
//    twelve-stage pipeline with one valid bit per stage sets that figure.
//  - Stalls: a stage holds its item only while the stage below is full, so
//    bubbles close up and up to twelve requests are taken while rsp_ready is
//    low. req_ready falls only when every stage holds an item.
//  - Reset clears all valid bits and sets n_states and n_sites to 1, masks
//    and rates to 0.
module multisite_occupancy_scale import msos_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [FRAC_W-1:0]       req_site_fraction_0,
   input  logic [FRAC_W-1:0]       req_site_fraction_1,
   input  logic [FRAC_W-1:0]       req_site_fraction_2,
   input  logic [FRAC_W-1:0]       req_site_fraction_3,
   input  logic [FRAC_W-1:0]       req_site_fraction_4,
   input  logic [FRAC_W-1:0]       req_site_fraction_5,
   input  logic [FRAC_W-1:0]       req_site_fraction_6,
   input  logic [FRAC_W-1:0]       req_site_fraction_7,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [SF_W-1:0]  rsp_rate_gain,
   output logic [FRAC_W-1:0]       rsp_occupancy_0,
   output logic [FRAC_W-1:0]       rsp_occupancy_1,
   output logic [FRAC_W-1:0]       rsp_occupancy_2,
   output logic [FRAC_W-1:0]       rsp_occupancy_3,
   output logic [FRAC_W-1:0]       rsp_occupancy_4,
   output logic [FRAC_W-1:0]       rsp_occupancy_5,
   output logic [FRAC_W-1:0]       rsp_occupancy_6,
   output logic [FRAC_W-1:0]       rsp_occupancy_7,
   input  logic                    csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_write_data
);

   cfg_type                         cfg;
   logic [PIPE_STAGES-1:0]          valid_ff, valid_in;
   logic [PIPE_STAGES:0]            stage_ready;
   logic [PIPE_STAGES-1:0]          stage_load;
   logic [PIPE_STAGES-1:0]          up_valid;
   frac_vec_type                    req_frac;
   logic [NUM_SITES-1:0][NUM_SITES-1:0][FRAC_W-1:0] frac_ff;
   frac_vec_type                    frac_diag;
   occ_vec_type                     lane_occ, occ_out;
   merge_ctl_type                   merge_ctl;
   logic [NUM_STATES-1:0][RATE_W-1:0] rates;

   msos_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   assign req_frac = {req_site_fraction_7, req_site_fraction_6,
                      req_site_fraction_5, req_site_fraction_4,
                      req_site_fraction_3, req_site_fraction_2,
                      req_site_fraction_1, req_site_fraction_0};

   // Stage handshake: a stage takes a new item when empty or draining
   always_comb begin
      stage_ready[PIPE_STAGES] = rsp_ready;
      for (int i = PIPE_STAGES - 1; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      up_valid = {valid_ff[PIPE_STAGES-2:0], req_valid};
      for (int i = 0; i < PIPE_STAGES; i++) begin
         stage_load[i] = stage_ready[i] && up_valid[i];
         valid_in[i]   = stage_ready[i] ? up_valid[i] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Fraction delay line; stage 0 clamps to 1.0
   always_ff @(posedge clock) begin
      if (stage_load[0]) begin
         for (int j = 0; j < NUM_SITES; j++) begin
            frac_ff[0][j] <= (req_frac[j] > ONE_Q15) ? ONE_Q15 : req_frac[j];
         end
      end
      for (int k = 1; k < NUM_SITES; k++) begin
         if (stage_load[k]) begin
            frac_ff[k] <= frac_ff[k-1];
         end
      end
   end

   // Site j is consumed by the lane stage fed from delay stage j
   always_comb begin
      for (int j = 0; j < NUM_SITES; j++) begin
         frac_diag[j] = frac_ff[j][j];
      end
   end

   // One lane per state
   for (genvar s = 0; s < NUM_STATES; s++) begin : g_lane
      msos_lane u_lane (
         .clock         (clock),
         .stage_load    (stage_load[NUM_SITES:1]),
         .frac_in       (frac_diag),
         .care_bits     (cfg.care_mask[s*NUM_SITES +: NUM_SITES]),
         .occupied_bits (cfg.occupied_mask[s*NUM_SITES +: NUM_SITES]),
         .n_sites       (cfg.n_sites),
         .occ_out       (lane_occ[s])
      );
   end

   assign rates = {cfg.rates_high, cfg.rates_low};

   assign merge_ctl.term_load = stage_load[NUM_SITES+1];
   assign merge_ctl.pair_load = stage_load[NUM_SITES+2];
   assign merge_ctl.out_load  = stage_load[NUM_SITES+3];

   msos_merge u_merge (
      .clock    (clock),
      .ctl      (merge_ctl),
      .occ_in   (lane_occ),
      .rates    (rates),
      .n_states (cfg.n_states),
      .occ_out  (occ_out),
      .sf_out   (rsp_rate_gain)
   );

   assign req_ready       = stage_ready[0];
   assign rsp_valid       = valid_ff[PIPE_STAGES-1];
   assign rsp_occupancy_0 = occ_out[0];
   assign rsp_occupancy_1 = occ_out[1];
   assign rsp_occupancy_2 = occ_out[2];
   assign rsp_occupancy_3 = occ_out[3];
   assign rsp_occupancy_4 = occ_out[4];
   assign rsp_occupancy_5 = occ_out[5];
   assign rsp_occupancy_6 = occ_out[6];
   assign rsp_occupancy_7 = occ_out[7];

   // Back-pressure only when the whole pipeline is full
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (valid_ff == '1))
      else $error("request stalled with an empty stage");

   // Item count grows by one on a lone request
   a_fill_up: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !(rsp_valid && rsp_ready)) |=>
      ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("request lost or duplicated in pipeline");

   // Item count shrinks by one on a lone response
   a_fill_down: assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && rsp_valid && rsp_ready) |=>
      ($countones(valid_ff) + 1 == $past($countones(valid_ff))))
      else $error("response lost or duplicated in pipeline");

   // Occupancies 0 and 7 never exceed 1.0
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_occupancy_0 <= ONE_Q15 && rsp_occupancy_7 <= ONE_Q15))
      else $error("occupancy above one");

endmodule

### tb/multisite_occupancy_scale_tb.sv
// Self-checking testbench for multisite_occupancy_scale: occupancy products and scale factor.
// Depends on msos_pkg and the multisite_occupancy_scale RTL only; reads no files.
// Predicts each response in-line and checks it in order against the response channel.
module multisite_occupancy_scale_tb import msos_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   // Spare register indexes that the block must drop
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_7 = 3'd7;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_ITEMS  = 200;
   localparam int SETS_PER_PHASE = 4;

   typedef struct packed {
      logic signed [SF_W-1:0] rate_gain;
      occ_vec_type            occ;
   } occ_result_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [FRAC_W-1:0] req_site_fraction_0, req_site_fraction_1;
   logic [FRAC_W-1:0] req_site_fraction_2, req_site_fraction_3;
   logic [FRAC_W-1:0] req_site_fraction_4, req_site_fraction_5;
   logic [FRAC_W-1:0] req_site_fraction_6, req_site_fraction_7;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [SF_W-1:0] rsp_rate_gain;
   logic [FRAC_W-1:0] rsp_occupancy_0, rsp_occupancy_1, rsp_occupancy_2, rsp_occupancy_3;
   logic [FRAC_W-1:0] rsp_occupancy_4, rsp_occupancy_5, rsp_occupancy_6, rsp_occupancy_7;
   logic csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   // Shadow copy of the register file, updated as each write lands
   cfg_type        shadow_cfg;
   occ_result_type pending_results[$];
   int             send_idle_pct;
   int             recv_stall_pct;
   int             error_count;
   int             requests_sent;
   int             responses_checked;
   int             settings_loaded;
   int             cycle_count;

   multisite_occupancy_scale dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_site_fraction_0 (req_site_fraction_0),
      .req_site_fraction_1 (req_site_fraction_1),
      .req_site_fraction_2 (req_site_fraction_2),
      .req_site_fraction_3 (req_site_fraction_3),
      .req_site_fraction_4 (req_site_fraction_4),
      .req_site_fraction_5 (req_site_fraction_5),
      .req_site_fraction_6 (req_site_fraction_6),
      .req_site_fraction_7 (req_site_fraction_7),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_rate_gain       (rsp_rate_gain),
      .rsp_occupancy_0     (rsp_occupancy_0),
      .rsp_occupancy_1     (rsp_occupancy_1),
      .rsp_occupancy_2     (rsp_occupancy_2),
      .rsp_occupancy_3     (rsp_occupancy_3),
      .rsp_occupancy_4     (rsp_occupancy_4),
      .rsp_occupancy_5     (rsp_occupancy_5),
      .rsp_occupancy_6     (rsp_occupancy_6),
      .rsp_occupancy_7     (rsp_occupancy_7),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Occupancy of each active state and the saturated Q12.16 scale factor
   function automatic occ_result_type predict_occupancy(input frac_vec_type raw);
      occ_result_type r;
      logic [FRAC_W-1:0] frac [NUM_SITES];
      int     active_states;
      int     active_sites;
      int     pos;
      longint occ;
      longint factor;
      longint rate;
      longint total;
      longint sf;
      for (int j = 0; j < NUM_SITES; j++)
         frac[j] = (raw[j] > ONE_Q15) ? ONE_Q15 : raw[j];
      active_states = (shadow_cfg.n_states > NUM_STATES) ? NUM_STATES : shadow_cfg.n_states;
      active_sites  = (shadow_cfg.n_sites > NUM_SITES) ? NUM_SITES : shadow_cfg.n_sites;
      r = '0;
      // 1.0 in Q.23
      total = longint'(1) << 23;
      for (int s = 0; s < active_states; s++) begin
         occ = ONE_Q15;
         for (int j = 0; j < active_sites; j++) begin
            pos = s * 8 + j;
            if (shadow_cfg.care_mask[pos]) begin
               factor = shadow_cfg.occupied_mask[pos] ? longint'(frac[j])
                                                      : longint'(ONE_Q15) - frac[j];
               occ = (occ * factor + ROUND_Q15) >> 15;
            end
         end
         if (s < 4)
            rate = shadow_cfg.rates_low[RATE_W*s +: RATE_W];
         else
            rate = shadow_cfg.rates_high[RATE_W*(s-4) +: RATE_W];
         total = total - occ * 256 + occ * rate;
         r.occ[s] = occ[FRAC_W-1:0];
      end
      // Round Q.23 to the nearest Q16, then clamp
      sf = (total + 64) >>> 7;
      if (sf > SF_HI) sf = SF_HI;
      if (sf < SF_LO) sf = SF_LO;
      r.rate_gain = sf[SF_W-1:0];
      return r;
   endfunction

   function automatic frac_vec_type uniform_fractions(input logic [FRAC_W-1:0] v);
      frac_vec_type f;
      for (int j = 0; j < NUM_SITES; j++)
         f[j] = v;
      return f;
   endfunction

   // Mostly legal fractions, with exact ends and some above one
   function automatic frac_vec_type random_fractions();
      frac_vec_type f;
      for (int j = 0; j < NUM_SITES; j++) begin
         case ($urandom_range(9))
            0: f[j] = '0;
            1: f[j] = ONE_Q15;
            2: f[j] = FRAC_W'($urandom_range(65535));
            default: f[j] = FRAC_W'($urandom_range(32768));
         endcase
      end
      return f;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_word();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Count register with junk above the 4-bit field; mostly 1..8
   function automatic logic [CSR_DATA_W-1:0] random_count();
      logic [CSR_DATA_W-1:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(9))
         0: w[COUNT_W-1:0] = '0;
         1: w[COUNT_W-1:0] = COUNT_W'($urandom_range(9, 15));
         default: w[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 8));
      endcase
      return w;
   endfunction

   // One request, with random idle cycles ahead of it
   task automatic send_request(input frac_vec_type fr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_site_fraction_0 <= fr[0];
      req_site_fraction_1 <= fr[1];
      req_site_fraction_2 <= fr[2];
      req_site_fraction_3 <= fr[3];
      req_site_fraction_4 <= fr[4];
      req_site_fraction_5 <= fr[5];
      req_site_fraction_6 <= fr[6];
      req_site_fraction_7 <= fr[7];
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_occupancy(fr));
      requests_sent++;
   endtask

   // Stop sending and wait for every outstanding response
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (csr_index_type'(idx))
         CSR_N_STATES:      shadow_cfg.n_states      = data[COUNT_W-1:0];
         CSR_N_SITES:       shadow_cfg.n_sites       = data[COUNT_W-1:0];
         CSR_CARE_MASK:     shadow_cfg.care_mask     = data;
         CSR_OCCUPIED_MASK: shadow_cfg.occupied_mask = data;
         CSR_RATES_LOW:     shadow_cfg.rates_low     = data;
         CSR_RATES_HIGH:    shadow_cfg.rates_high    = data;
         default: ;
      endcase
   endtask

   // Full register setting, written only with the pipeline empty
   task automatic load_config(input logic [CSR_DATA_W-1:0] states_w,
                              input logic [CSR_DATA_W-1:0] sites_w,
                              input logic [CSR_DATA_W-1:0] care,
                              input logic [CSR_DATA_W-1:0] occupied,
                              input logic [CSR_DATA_W-1:0] rates_lo,
                              input logic [CSR_DATA_W-1:0] rates_hi);
      drain_responses();
      write_reg(CSR_N_STATES, states_w);
      write_reg(CSR_N_SITES, sites_w);
      write_reg(CSR_CARE_MASK, care);
      write_reg(CSR_OCCUPIED_MASK, occupied);
      write_reg(CSR_RATES_LOW, rates_lo);
      write_reg(CSR_RATES_HIGH, rates_hi);
      csr_write_enable <= 1'b0;
      settings_loaded++;
   endtask

   // Reset values: one state, one site, no cared sites, zero rates
   task automatic test_reset_defaults();
      send_request(uniform_fractions('0));
      send_request(uniform_fractions('1));
   endtask

   // All sites cared, fully occupied then fully empty, rates at both ends
   task automatic test_fraction_extremes();
      frac_vec_type mix;
      load_config(64'd8, 64'd8, '1, '1, '1, '1);
      send_request(uniform_fractions('0));
      send_request(uniform_fractions(ONE_Q15));
      send_request(uniform_fractions('1));
      send_request(uniform_fractions(ONE_Q15 + 16'd1));
      load_config(64'd8, 64'd8, '1, '0, '0, '0);
      send_request(uniform_fractions('0));
      send_request(uniform_fractions(ONE_Q15));
      for (int j = 0; j < NUM_SITES; j++)
         mix[j] = j[0] ? 16'h5555 : 16'h2aaa;
      send_request(mix);
   endtask

   // Zero, clamped and partial state and site counts
   task automatic test_count_limits();
      load_config(64'd0, 64'd8, '1, {$urandom, $urandom}, '1, '1);
      send_request(random_fractions());
      load_config(64'd8, 64'd0, '1, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom});
      send_request(random_fractions());
      load_config({60'hfedcba987654321, 4'd15}, {60'h123456789abcdef, 4'd9}, '1,
                  {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      send_request(random_fractions());
      send_request(random_fractions());
      load_config(64'd3, 64'd5, '1, {$urandom, $urandom}, {$urandom, $urandom},
                  {$urandom, $urandom});
      send_request(random_fractions());
      send_request(uniform_fractions(ONE_Q15));
   endtask

   // Writes to indexes past the register list must change nothing
   task automatic test_unknown_index();
      drain_responses();
      write_reg(CSR_SPARE_6, {$urandom, $urandom});
      write_reg(CSR_SPARE_7, {$urandom, $urandom});
      csr_write_enable <= 1'b0;
      send_request(random_fractions());
      send_request(random_fractions());
   endtask

   // Random settings (all-ones first when send_pct is 0) and fractions under one pair of idle rates
   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      for (int c = 0; c < SETS_PER_PHASE; c++) begin
         if (c == 0 && send_pct == 0)
            load_config(64'd8, 64'd8, '1, '1, '1, '1);
         else
            load_config(random_count(), random_count(), random_word(), random_word(),
                        random_word(), random_word());
         for (int i = 0; i < PHASE_ITEMS / SETS_PER_PHASE; i++) begin
            send_request(random_fractions());
            // Hold the sender once per setting until the pipeline is empty
            if (i == PHASE_ITEMS / (2 * SETS_PER_PHASE))
               drain_responses();
         end
      end
   endtask

   // Response side: random backpressure and in-order compare
   initial begin
      occ_result_type want;
      occ_vec_type    got;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got = {rsp_occupancy_7, rsp_occupancy_6, rsp_occupancy_5, rsp_occupancy_4,
                   rsp_occupancy_3, rsp_occupancy_2, rsp_occupancy_1, rsp_occupancy_0};
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding: rate_gain %0d",
                      rsp_rate_gain);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               responses_checked++;
               if (want.rate_gain !== rsp_rate_gain) begin
                  $error("rate_gain: expected %0d, got %0d",
                         $signed(want.rate_gain), rsp_rate_gain);
                  error_count++;
               end
               for (int k = 0; k < NUM_STATES; k++) begin
                  if (want.occ[k] !== got[k]) begin
                     $error("occupancy_%0d: expected %0d, got %0d", k, want.occ[k], got[k]);
                     error_count++;
                  end
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_results.size());
      $display("multisite_occupancy_scale_tb: errors");
      $finish;
   end

   // Main sequence
   initial begin
      cycle_count       = 0;
      error_count       = 0;
      requests_sent     = 0;
      responses_checked = 0;
      settings_loaded   = 0;
      send_idle_pct     = 32;
      recv_stall_pct    = 84;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_site_fraction_0 <= '0;
      req_site_fraction_1 <= '0;
      req_site_fraction_2 <= '0;
      req_site_fraction_3 <= '0;
      req_site_fraction_4 <= '0;
      req_site_fraction_5 <= '0;
      req_site_fraction_6 <= '0;
      req_site_fraction_7 <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= '0;
      csr_write_data      <= '0;
      shadow_cfg = '0;
      shadow_cfg.n_states = COUNT_W'(1);
      shadow_cfg.n_sites  = COUNT_W'(1);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_fraction_extremes();
      test_count_limits();
      test_unknown_index();
      test_random_traffic(32, 84);
      test_random_traffic(84, 32);
      test_random_traffic(0, 0);

      // Let any stray response surface before the verdict
      drain_responses();
      repeat (PIPE_STAGES + 8) @(posedge clock);
      if (pending_results.size() != 0) begin
         $error("%0d responses never arrived", pending_results.size());
         error_count++;
      end
      $display("%0d requests sent, %0d responses checked, %0d register settings loaded",
               requests_sent, responses_checked, settings_loaded);
      $display("covered count limits, spare indexes, fraction extremes and three idle mixes");
      if (error_count == 0)
         $display("multisite_occupancy_scale_tb: clean");
      else
         $display("multisite_occupancy_scale_tb: errors");
      $finish;
   end

endmodule

### multisite_occupancy_scale.f
rtl/core/msos_pkg.sv
rtl/core/msos_csr.sv
rtl/core/msos_lane.sv
rtl/core/msos_merge.sv
rtl/core/multisite_occupancy_scale.sv
tb/multisite_occupancy_scale_tb.sv
